// File: design/rpn_pkg.sv
// Shared types and constants for the reverse Polish evaluator.
// Used by the stack cells, the divider, the top level and the checker.
// No dependencies.
package rpn_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int SYMBOL_W    = 8;
   localparam int STATUS_W    = 3;
   localparam int DIV_STEPS   = DATA_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [SYMBOL_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYMBOL_W-1:0] SYM_MINUS = 8'h2D;
   localparam logic [SYMBOL_W-1:0] SYM_STAR  = 8'h2A;
   localparam logic [SYMBOL_W-1:0] SYM_SLASH = 8'h2F;
   localparam logic [SYMBOL_W-1:0] SYM_EQUAL = 8'h3D;
   localparam logic [SYMBOL_W-1:0] SYM_ZERO  = 8'h30;
   localparam logic [SYMBOL_W-1:0] SYM_NINE  = 8'h39;
   localparam logic [SYMBOL_W-1:0] SYM_SPACE = 8'h20;
   localparam logic [SYMBOL_W-1:0] SYM_TAB   = 8'h09;
   localparam logic [SYMBOL_W-1:0] SYM_CR    = 8'h0D;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_VALUE     = 3'd0,
      STATUS_OVERFLOW  = 3'd1,
      STATUS_UNDERFLOW = 3'd2,
      STATUS_DIVZERO   = 3'd3,
      STATUS_END       = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_DOWN,
      CELL_UP
   } cell_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: design/rpn_cell.sv
// One entry of the operand stack, moving toward the bottom on push and
// toward the top on pop. Depends on rpn_pkg.
module rpn_cell (
   input  logic                         clock,
   input  rpn_pkg::cell_cmd_type        cmd,
   input  logic [rpn_pkg::DATA_W-1:0]   down_data,
   input  logic [rpn_pkg::DATA_W-1:0]   up_data,
   output logic [rpn_pkg::DATA_W-1:0]   data
);

   logic [rpn_pkg::DATA_W-1:0] data_ff;
   logic [rpn_pkg::DATA_W-1:0] data_in;

   always_comb begin
      case (cmd)
         rpn_pkg::CELL_DOWN: data_in = down_data;
         rpn_pkg::CELL_UP:   data_in = up_data;
         default:            data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// File: design/rpn_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg.
module rpn_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rpn_pkg::DATA_W-1:0]    dividend,
   input  logic [rpn_pkg::DATA_W-1:0]    divisor,
   output logic [rpn_pkg::DATA_W-1:0]    quotient,
   output rpn_pkg::div_status_type       status
);

   logic [rpn_pkg::DATA_W-1:0]    rem_ff, rem_in;
   logic [rpn_pkg::DATA_W-1:0]    quo_ff, quo_in;
   logic [rpn_pkg::DATA_W-1:0]    den_ff, den_in;
   logic                          neg_ff, neg_in;
   logic [rpn_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [rpn_pkg::DATA_W:0]      shifted;
   logic                          fits;

   assign shifted = {rem_ff, quo_ff[rpn_pkg::DATA_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[rpn_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
         den_in  = divisor[rpn_pkg::DATA_W-1] ? (~divisor + 1'b1) : divisor;
         neg_in  = dividend[rpn_pkg::DATA_W-1] ^ divisor[rpn_pkg::DATA_W-1];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? shifted[rpn_pkg::DATA_W-1:0] - den_ff
                       : shifted[rpn_pkg::DATA_W-1:0];
         quo_in = {quo_ff[rpn_pkg::DATA_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rpn_pkg::DIV_CNT_W'(rpn_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: design/rpn_stack_evaluator.sv
// Top level of the reverse Polish evaluator: decode, stack of shifting cells,
// divider and result register. Depends on rpn_pkg, rpn_cell, rpn_divider.
//
//   channel | direction | ports                         | beat
//   req     | in        | req_valid req_stall req_symbol | one ASCII symbol
//   rsp     | out       | rsp_valid rsp_stall rsp_value  | value and status
//           |           | rsp_status                     |
//
// Digits, + - * =, whitespace and other symbols never hold req stalled.
// Division runs the 32 steps of the bit-serial divider, then writes the
// quotient back; req_stall stays high meanwhile.
// A waiting result stalls req only while rsp is stalled.
// Synchronous reset empties the stack and drops any waiting result.
module rpn_stack_evaluator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rpn_pkg::SYMBOL_W-1:0]     req_symbol,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [rpn_pkg::DATA_W-1:0] rsp_value,
   output logic [rpn_pkg::STATUS_W-1:0]     rsp_status
);

   localparam int DEPTH = rpn_pkg::STACK_DEPTH;
   localparam int DW    = rpn_pkg::DATA_W;

   rpn_pkg::state_type          state_ff, state_in;
   logic [rpn_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        rsp_valid_ff;
   logic [DW-1:0]               rsp_value_ff;
   rpn_pkg::status_type         rsp_status_ff;

   logic                        result_new;
   logic [DW-1:0]               result_value;
   rpn_pkg::status_type         result_status;
   logic                        div_start;
   rpn_pkg::cell_cmd_type       cmd_top, cmd_rest;
   logic [DW-1:0]               load_value;

   logic                        is_digit, is_op, is_equal, is_space;
   logic                        has_one, has_two, is_full;
   logic [DW-1:0]               cell_data [DEPTH];
   logic [DW-1:0]               top_b, top_a;
   logic [DW-1:0]               product;
   logic [DW-1:0]               quotient;
   rpn_pkg::div_status_type     div_status;

   assign top_b   = cell_data[0];
   assign top_a   = cell_data[1];
   assign product = top_a * top_b;
   assign has_one = count_ff != '0;
   assign has_two = count_ff >= rpn_pkg::COUNT_W'(2);
   assign is_full = count_ff >= rpn_pkg::COUNT_W'(DEPTH);

   always_comb begin
      is_digit = req_symbol inside {[rpn_pkg::SYM_ZERO:rpn_pkg::SYM_NINE]};
      is_op    = req_symbol inside {rpn_pkg::SYM_PLUS, rpn_pkg::SYM_MINUS,
                                    rpn_pkg::SYM_STAR, rpn_pkg::SYM_SLASH};
      is_equal = req_symbol == rpn_pkg::SYM_EQUAL;
      is_space = req_symbol inside {rpn_pkg::SYM_SPACE,
                                    [rpn_pkg::SYM_TAB:rpn_pkg::SYM_CR]};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpn_pkg::ST_IDLE: begin
            if (div_start) state_in = rpn_pkg::ST_DIVIDE;
         end
         rpn_pkg::ST_DIVIDE: begin
            if (div_status.done) state_in = rpn_pkg::ST_IDLE;
         end
         default: state_in = rpn_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall     = 1'b1;
      result_new    = 1'b0;
      result_value  = '0;
      result_status = rpn_pkg::STATUS_VALUE;
      div_start     = 1'b0;
      cmd_top       = rpn_pkg::CELL_HOLD;
      cmd_rest      = rpn_pkg::CELL_HOLD;
      load_value    = '0;
      count_in      = count_ff;
      case (state_ff)
         rpn_pkg::ST_IDLE: begin
            req_stall = rsp_valid_ff && rsp_stall;
            if (req_valid && !req_stall) begin
               if (is_digit) begin
                  if (is_full) begin
                     result_new    = 1'b1;
                     result_status = rpn_pkg::STATUS_OVERFLOW;
                     count_in      = '0;
                  end else begin
                     load_value = {{(DW-4){1'b0}}, req_symbol[3:0]};
                     cmd_top    = rpn_pkg::CELL_DOWN;
                     cmd_rest   = rpn_pkg::CELL_DOWN;
                     count_in   = count_ff + 1'b1;
                  end
               end else if (is_op) begin
                  if (!has_two) begin
                     result_new    = 1'b1;
                     result_status = rpn_pkg::STATUS_UNDERFLOW;
                     count_in      = '0;
                  end else if (req_symbol == rpn_pkg::SYM_SLASH) begin
                     if (top_b == '0) begin
                        result_new    = 1'b1;
                        result_status = rpn_pkg::STATUS_DIVZERO;
                        count_in      = '0;
                     end else begin
                        div_start = 1'b1;
                     end
                  end else begin
                     case (req_symbol)
                        rpn_pkg::SYM_PLUS:  load_value = top_a + top_b;
                        rpn_pkg::SYM_MINUS: load_value = top_a - top_b;
                        default:            load_value = product;
                     endcase
                     cmd_top  = rpn_pkg::CELL_DOWN;
                     cmd_rest = rpn_pkg::CELL_UP;
                     count_in = count_ff - 1'b1;
                  end
               end else if (is_equal) begin
                  result_new    = 1'b1;
                  result_status = has_one ? rpn_pkg::STATUS_VALUE
                                          : rpn_pkg::STATUS_UNDERFLOW;
                  result_value  = has_one ? top_b : '0;
                  count_in      = '0;
               end else if (!is_space) begin
                  result_new    = 1'b1;
                  result_status = rpn_pkg::STATUS_END;
                  count_in      = '0;
               end
            end
         end
         rpn_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               load_value = quotient;
               cmd_top    = rpn_pkg::CELL_DOWN;
               cmd_rest   = rpn_pkg::CELL_UP;
               count_in   = count_ff - 1'b1;
            end
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpn_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (result_new) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (result_new) begin
         rsp_value_ff  <= result_value;
         rsp_status_ff <= result_status;
      end
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic [DW-1:0]         down_data;
         logic [DW-1:0]         up_data;
         rpn_pkg::cell_cmd_type cmd;
         if (i == 0) begin : g_head
            assign down_data = load_value;
            assign cmd       = cmd_top;
         end else begin : g_body
            assign down_data = cell_data[i-1];
            assign cmd       = cmd_rest;
         end
         if (i == DEPTH - 1) begin : g_tail
            assign up_data = cell_data[i];
         end else begin : g_link
            assign up_data = cell_data[i+1];
         end
         rpn_cell u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .down_data (down_data),
            .up_data   (up_data),
            .data      (cell_data[i])
         );
      end
   endgenerate

   rpn_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (top_a),
      .divisor  (top_b),
      .quotient (quotient),
      .status   (div_status)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// File: design/rpn_checker.sv
// Port-level checks for the reverse Polish evaluator, bound to its top level.
// Depends on rpn_pkg and rpn_stack_evaluator.
module rpn_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [rpn_pkg::SYMBOL_W-1:0]     req_symbol,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [rpn_pkg::DATA_W-1:0]       rsp_value,
   input logic [rpn_pkg::STATUS_W-1:0]     rsp_status
);

   a_reset_drops_beat: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rpn_pkg::STATUS_VALUE |-> rsp_value == '0)
      else $error("error beat carries nonzero value");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= rpn_pkg::STATUS_END)
      else $error("status code out of range");

   a_space_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_symbol == rpn_pkg::SYM_SPACE && !rsp_valid
      |=> !rsp_valid)
      else $error("whitespace produced a result beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value)
                                 && $stable(rsp_status))
      else $error("stalled result beat changed");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_symbol (req_symbol),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_value  (rsp_value),
   .rsp_status (rsp_status)
);

// File: tb/rpn_stack_evaluator_checker.sv
`timescale 1ns / 100ps
// Scoreboard for rpn_stack_evaluator: watches the req and rsp channels, predicts
// every result from a shadow copy of the operand stack and compares each rsp beat.
// Depends on rpn_pkg.
module rpn_stack_evaluator_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [rpn_pkg::SYMBOL_W-1:0]       req_symbol,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [rpn_pkg::DATA_W-1:0]  rsp_value,
   input  logic [rpn_pkg::STATUS_W-1:0]       rsp_status,
   output int                                 mismatch_count,
   output int                                 waiting_count,
   output int                                 checked_count
);

   typedef struct {
      logic [rpn_pkg::DATA_W-1:0] value;
      rpn_pkg::status_type        status;
   } answer_type;

   logic [rpn_pkg::DATA_W-1:0] shadow_stack [rpn_pkg::STACK_DEPTH];
   int                         shadow_depth;
   answer_type                 pending_answers [$];
   answer_type                 oldest;

   function automatic logic [rpn_pkg::DATA_W-1:0] trunc_divide(
      input logic [rpn_pkg::DATA_W-1:0] num,
      input logic [rpn_pkg::DATA_W-1:0] den);
      logic [rpn_pkg::DATA_W-1:0] num_mag;
      logic [rpn_pkg::DATA_W-1:0] den_mag;
      logic [rpn_pkg::DATA_W-1:0] quot;
      num_mag = num[rpn_pkg::DATA_W-1] ? -num : num;
      den_mag = den[rpn_pkg::DATA_W-1] ? -den : den;
      quot    = num_mag / den_mag;
      return (num[rpn_pkg::DATA_W-1] != den[rpn_pkg::DATA_W-1]) ? -quot : quot;
   endfunction

   task automatic post_answer(input logic [rpn_pkg::DATA_W-1:0] value,
                              input rpn_pkg::status_type status);
      answer_type entry;
      entry.value  = value;
      entry.status = status;
      pending_answers.push_back(entry);
      shadow_depth = 0;
   endtask

   task automatic evaluate_symbol(input logic [rpn_pkg::SYMBOL_W-1:0] sym);
      logic [rpn_pkg::DATA_W-1:0] lhs;
      logic [rpn_pkg::DATA_W-1:0] rhs;
      logic [rpn_pkg::DATA_W-1:0] res;
      if (sym >= rpn_pkg::SYM_ZERO && sym <= rpn_pkg::SYM_NINE) begin
         if (shadow_depth >= rpn_pkg::STACK_DEPTH) begin
            post_answer('0, rpn_pkg::STATUS_OVERFLOW);
         end else begin
            shadow_stack[shadow_depth] = rpn_pkg::DATA_W'(sym - rpn_pkg::SYM_ZERO);
            shadow_depth++;
         end
      end else if (sym == rpn_pkg::SYM_PLUS || sym == rpn_pkg::SYM_MINUS
                   || sym == rpn_pkg::SYM_STAR || sym == rpn_pkg::SYM_SLASH) begin
         if (shadow_depth < 2) begin
            post_answer('0, rpn_pkg::STATUS_UNDERFLOW);
         end else begin
            rhs = shadow_stack[shadow_depth-1];
            lhs = shadow_stack[shadow_depth-2];
            if (sym == rpn_pkg::SYM_SLASH && rhs == '0) begin
               post_answer('0, rpn_pkg::STATUS_DIVZERO);
            end else begin
               case (sym)
                  rpn_pkg::SYM_PLUS:  res = lhs + rhs;
                  rpn_pkg::SYM_MINUS: res = lhs - rhs;
                  rpn_pkg::SYM_STAR:  res = lhs * rhs;
                  default:            res = trunc_divide(lhs, rhs);
               endcase
               shadow_depth--;
               shadow_stack[shadow_depth-1] = res;
            end
         end
      end else if (sym == rpn_pkg::SYM_EQUAL) begin
         if (shadow_depth == 0) begin
            post_answer('0, rpn_pkg::STATUS_UNDERFLOW);
         end else begin
            post_answer(shadow_stack[shadow_depth-1], rpn_pkg::STATUS_VALUE);
         end
      end else if (!(sym == rpn_pkg::SYM_SPACE
                     || (sym >= rpn_pkg::SYM_TAB && sym <= rpn_pkg::SYM_CR))) begin
         post_answer('0, rpn_pkg::STATUS_END);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_depth = 0;
         pending_answers.delete();
      end else begin
         if (req_valid && !req_stall) begin
            evaluate_symbol(req_symbol);
         end
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            if (pending_answers.size() == 0) begin
               $error("unexpected rsp beat: value %0d status %0d", rsp_value, rsp_status);
               mismatch_count++;
            end else begin
               oldest = pending_answers.pop_front();
               if (rsp_value !== oldest.value) begin
                  $error("value: expected %0d, actual %0d",
                         $signed(oldest.value), rsp_value);
                  mismatch_count++;
               end
               if (rsp_status !== oldest.status) begin
                  $error("status: expected %0d, actual %0d", oldest.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
      end
      waiting_count = pending_answers.size();
   end

endmodule

// File: tb/rpn_stack_evaluator_tb.sv
`timescale 1ns / 100ps
// Top of the rpn_stack_evaluator testbench: clock, reset, symbol stimulus and
// rsp back-pressure; verdict from rpn_stack_evaluator_checker. Depends on rpn_pkg.
module rpn_stack_evaluator_tb;

   localparam int SYMBOL_TARGET   = 850;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 40;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [rpn_pkg::SYMBOL_W-1:0]      req_symbol;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic signed [rpn_pkg::DATA_W-1:0] rsp_value;
   logic [rpn_pkg::STATUS_W-1:0]      rsp_status;

   int mismatch_count;
   int waiting_count;
   int checked_count;
   int cycle_count;
   int symbols_sent;
   int send_idle_pct;
   int stall_pct;
   int hold_requests;

   logic [rpn_pkg::SYMBOL_W-1:0] opening_symbols [$];

   rpn_stack_evaluator dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_symbol (req_symbol),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   rpn_stack_evaluator_checker watch (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_symbol     (req_symbol),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .mismatch_count (mismatch_count),
      .waiting_count  (waiting_count),
      .checked_count  (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL rpn_stack_evaluator");
         $finish;
      end
   end

   initial begin : receiver
      int holds_served;
      int hold_left;
      holds_served = 0;
      hold_left    = 0;
      rsp_stall    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   function automatic logic [rpn_pkg::SYMBOL_W-1:0] random_digit();
      return rpn_pkg::SYM_ZERO + rpn_pkg::SYMBOL_W'($urandom_range(0, 9));
   endfunction

   function automatic logic [rpn_pkg::SYMBOL_W-1:0] random_operator();
      case ($urandom_range(0, 3))
         0:       return rpn_pkg::SYM_PLUS;
         1:       return rpn_pkg::SYM_MINUS;
         2:       return rpn_pkg::SYM_STAR;
         default: return rpn_pkg::SYM_SLASH;
      endcase
   endfunction

   function automatic logic [rpn_pkg::SYMBOL_W-1:0] random_space();
      if ($urandom_range(0, 5) == 0) begin
         return rpn_pkg::SYM_SPACE;
      end
      return rpn_pkg::SYM_TAB + rpn_pkg::SYMBOL_W'($urandom_range(0, 4));
   endfunction

   function automatic logic [rpn_pkg::SYMBOL_W-1:0] random_terminator();
      logic [rpn_pkg::SYMBOL_W-1:0] sym;
      do begin
         sym = rpn_pkg::SYMBOL_W'($urandom_range(0, 255));
      end while ((sym >= rpn_pkg::SYM_ZERO && sym <= rpn_pkg::SYM_NINE)
                 || sym == rpn_pkg::SYM_PLUS || sym == rpn_pkg::SYM_MINUS
                 || sym == rpn_pkg::SYM_STAR || sym == rpn_pkg::SYM_SLASH
                 || sym == rpn_pkg::SYM_EQUAL || sym == rpn_pkg::SYM_SPACE
                 || (sym >= rpn_pkg::SYM_TAB && sym <= rpn_pkg::SYM_CR));
      return sym;
   endfunction

   // call at a falling edge; returns at the falling edge after the beat
   task automatic send_symbol(input logic [rpn_pkg::SYMBOL_W-1:0] sym);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_symbol <= sym;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
      if (!(sym == rpn_pkg::SYM_SPACE
            || (sym >= rpn_pkg::SYM_TAB && sym <= rpn_pkg::SYM_CR))) begin
         symbols_sent++;
      end
   endtask

   task automatic send_expression();
      int operands_left;
      int depth;
      operands_left = $urandom_range(1, 8);
      depth         = 0;
      while (operands_left > 0 || depth > 1) begin
         if (operands_left > 0 && (depth < 2 || $urandom_range(0, 1) == 0)) begin
            send_symbol(random_digit());
            operands_left--;
            depth++;
         end else begin
            send_symbol(random_operator());
            depth--;
         end
         if ($urandom_range(0, 7) == 0) begin
            send_symbol(random_space());
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         send_symbol(random_terminator());
      end else begin
         send_symbol(rpn_pkg::SYM_EQUAL);
      end
   endtask

   task automatic send_broken();
      case ($urandom_range(0, 2))
         0: send_symbol(random_operator());
         1: begin
            send_symbol(random_digit());
            send_symbol(random_operator());
         end
         default: send_symbol(rpn_pkg::SYM_EQUAL);
      endcase
   endtask

   // build 2^31 from 2 * 8^10, then divide by 0 - 1
   task automatic send_min_by_minus_one();
      send_symbol(rpn_pkg::SYM_ZERO + 8'd2);
      repeat (10) begin
         send_symbol(rpn_pkg::SYM_ZERO + 8'd8);
         send_symbol(rpn_pkg::SYM_STAR);
      end
      send_symbol(rpn_pkg::SYM_ZERO);
      send_symbol(rpn_pkg::SYM_ZERO + 8'd1);
      send_symbol(rpn_pkg::SYM_MINUS);
      send_symbol(rpn_pkg::SYM_SLASH);
      send_symbol(rpn_pkg::SYM_EQUAL);
   endtask

   task automatic fill_stack();
      send_symbol(random_terminator());
      repeat (rpn_pkg::STACK_DEPTH) send_symbol(random_digit());
      if ($urandom_range(0, 1) == 0) begin
         send_symbol(random_digit());
      end else begin
         send_symbol(rpn_pkg::SYM_EQUAL);
      end
   endtask

   initial begin : stimulus
      int base;
      int target;
      int pick;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_symbol    = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_requests = 0;
      symbols_sent  = 0;
      cycle_count   = 0;
      opening_symbols = '{8'h00, 8'hFF, rpn_pkg::SYM_EQUAL,
                          rpn_pkg::SYM_ZERO + 8'd5, rpn_pkg::SYM_PLUS,
                          rpn_pkg::SYM_NINE, rpn_pkg::SYM_ZERO, rpn_pkg::SYM_SLASH,
                          rpn_pkg::SYM_NINE, rpn_pkg::SYM_ZERO + 8'd3,
                          rpn_pkg::SYM_MINUS, rpn_pkg::SYM_ZERO + 8'd4,
                          rpn_pkg::SYM_STAR, rpn_pkg::SYM_EQUAL,
                          rpn_pkg::SYM_ZERO, rpn_pkg::SYM_ZERO + 8'd7,
                          rpn_pkg::SYM_MINUS, rpn_pkg::SYM_ZERO + 8'd2,
                          rpn_pkg::SYM_SLASH, rpn_pkg::SYM_EQUAL,
                          rpn_pkg::SYM_SPACE, rpn_pkg::SYM_TAB, 8'h0A, 8'h0B, 8'h0C,
                          rpn_pkg::SYM_CR, rpn_pkg::SYM_EQUAL};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (opening_symbols[i]) send_symbol(opening_symbols[i]);

      base = symbols_sent;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 65; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
         endcase
         target = base + (phase + 1) * SYMBOL_TARGET / 4;
         if (phase == 0) begin
            fill_stack();
         end
         while (symbols_sent < target) begin
            if (phase == 0 && hold_requests == 0
                && symbols_sent >= target - SYMBOL_TARGET / 8) begin
               hold_requests++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
               send_expression();
            end else if (pick < 76) begin
               send_broken();
            end else if (pick < 90) begin
               repeat ($urandom_range(1, 4))
                  send_symbol(rpn_pkg::SYMBOL_W'($urandom_range(0, 255)));
            end else if (pick < 97) begin
               send_min_by_minus_one();
            end else begin
               fill_stack();
            end
         end
      end
      req_valid <= 1'b0;
      stall_pct = 0;

      while (waiting_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d symbols over four idle mixes and one long rsp hold-off",
               symbols_sent);
      $display("checked %0d result beats", checked_count);
      if (mismatch_count == 0) begin
         $display("PASS rpn_stack_evaluator");
      end else begin
         $display("FAIL rpn_stack_evaluator");
      end
      $finish;
   end

endmodule
